FILE: rtl/tre_pkg.sv
// Shared types and constants for the triangle edge rasterizer.
package tre_pkg;

    localparam int POS_W      = 20;
    localparam int DEPTH_W    = 16;
    localparam int COLOR_W    = 8;
    localparam int PIX_W      = 12;
    localparam int SCREEN_W   = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int QUO_W      = 16;
    localparam int CNT_W      = $clog2(QUO_W);
    localparam int VTX_COUNT  = 3;
    localparam int LANES      = 4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic [1:0] VTX_LAST = 2'd2;
    localparam logic [CNT_W-1:0] MAC_LAST = CNT_W'(VTX_COUNT - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SCALE   = 2'd2;

    localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 13'd480;
    localparam logic [DEPTH_W-1:0]  DEPTH_SCALE_RST   = 16'hFFFF;
    localparam logic [DEPTH_W-1:0]  DEPTH_ONE         = 16'hFFFF;
    localparam logic [COLOR_W-1:0]  COLOR_ONE         = 8'hFF;

    typedef struct packed {
        logic                     op;
        logic [1:0]               vertex_index;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic [DEPTH_W-1:0]       depth_in;
        logic [COLOR_W-1:0]       red_in;
        logic [COLOR_W-1:0]       green_in;
        logic [COLOR_W-1:0]       blue_in;
    } cmd_payload_t;

    typedef struct packed {
        logic                fragment_valid;
        logic [PIX_W-1:0]    frag_x;
        logic [PIX_W-1:0]    frag_y;
        logic [DEPTH_W-1:0]  frag_depth;
        logic [COLOR_W-1:0]  frag_red;
        logic [COLOR_W-1:0]  frag_green;
        logic [COLOR_W-1:0]  frag_blue;
        logic                scan_done;
    } frag_payload_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] wdata;
    } cfg_payload_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP_MUL,
        ST_SETUP_SUB,
        ST_SETUP_CHK,
        ST_CULL,
        ST_EDGE_MUL,
        ST_EDGE_SUB,
        ST_EDGE_CHK,
        ST_MAC,
        ST_DIV,
        ST_DEPTH,
        ST_RESULT
    } tre_state_t;

    typedef struct packed {
        logic       load_vtx;
        logic       setup_mul;
        logic       setup_sub;
        logic       setup_commit;
        logic       edge_mul;
        logic       edge_sub;
        logic       mac_en;
        logic [1:0] mac_sel;
        logic       div_step;
        logic       depth_mul;
        logic       pixel_load;
        logic       cull_load;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_active;
        logic cull;
        logic covered;
        logic out_busy;
    } dp_status_t;

endpackage

FILE: rtl/tre_stream_if.sv
// Valid/ready channel carrying one payload struct.
interface tre_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/triangle_edge_rasterizer_core.sv
// Top level of the triangle edge rasterizer: sequencer plus datapath.
//
// The block rasterizes one triangle at a time. Three vertices are sent on the
// cmd channel as load transactions (op 0); loading vertex 2 runs setup, which
// computes the signed area, the back-face flag and the screen-clamped bounding
// box. A culled triangle (zero area, off screen or an empty box) answers with
// one frag transaction that has scan_done set and all else zero. Each step
// transaction (op 1) then visits one pixel centre, x outer and y inner, and
// always answers with one frag transaction; scan_done marks the last pixel of
// the box. Steps sent with no scan in progress, and loads of vertex index 3,
// are absorbed without a result. A step on an uncovered pixel passes edge
// multiply, subtract and check before the result; a covered pixel also passes
// the barycentric multiply-accumulate and the restoring divider that forms one
// quotient bit per cycle for depth and all three colours at once, then depth
// scaling. A vertex 0 or 1 load leaves the sequencer idle. The result sits in
// an output register, so a waiting result only holds the next result back, not
// the next input transaction. Configuration writes are taken on the cfg channel
// at any time and should be made while idle.
module triangle_edge_rasterizer_core #(
    parameter int COORD_FRAC_BITS = 4,
    parameter int MAX_SCREEN      = 4096
) (
    input logic          clk,
    input logic          rst_n,
    tre_stream_if.sink   cmd,
    tre_stream_if.source frag,
    tre_stream_if.sink   cfg
);

    tre_pkg::dp_cmd_t    ctl;
    tre_pkg::dp_status_t st;

    // The sequencer issues the datapath commands from its state.
    tre_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (cmd.valid),
        .cmd_op           (cmd.data.op),
        .cmd_vertex_index (cmd.data.vertex_index),
        .st               (st),
        .cmd_ready        (cmd.ready),
        .ctl              (ctl)
    );

    // The datapath holds the vertices, the box, the scan position and the
    // output register, and owns the configuration registers.
    tre_datapath #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .MAX_SCREEN      (MAX_SCREEN)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_data (cmd.data),
        .ctl      (ctl),
        .st       (st),
        .cfg      (cfg),
        .frag     (frag)
    );

    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.pixel_load || ctl.cull_load) |-> (!frag.valid || frag.ready))
        else $error("result register loaded while occupied");

    // The sequencer issues at most one datapath command per cycle.
    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.load_vtx, ctl.setup_mul, ctl.setup_sub, ctl.setup_commit,
                  ctl.edge_mul, ctl.edge_sub, ctl.mac_en, ctl.div_step,
                  ctl.depth_mul, ctl.pixel_load, ctl.cull_load}))
        else $error("overlapping datapath commands");

    // An accepted step during a scan starts edge evaluation on the next cycle.
    a_step_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && (cmd.data.op == tre_pkg::OP_STEP) && st.scan_active)
        |=> ctl.edge_mul)
        else $error("accepted step did not start edge evaluation");

endmodule

FILE: rtl/tre_ctrl.sv
// Sequencer that steps the rasterizer datapath through setup and pixel work.
module tre_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  logic                  cmd_op,
    input  logic [1:0]            cmd_vertex_index,
    input  tre_pkg::dp_status_t   st,
    output logic                  cmd_ready,
    output tre_pkg::dp_cmd_t      ctl
);

    tre_pkg::tre_state_t              state_reg, state_next;
    logic [tre_pkg::CNT_W-1:0]        cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tre_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            tre_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd_op == tre_pkg::OP_STEP)
                    begin
                        if (st.scan_active)
                            state_next = tre_pkg::ST_EDGE_MUL;
                    end
                    else if (cmd_vertex_index == tre_pkg::VTX_LAST)
                    begin
                        state_next = tre_pkg::ST_SETUP_MUL;
                    end
                end
            end
            tre_pkg::ST_SETUP_MUL: state_next = tre_pkg::ST_SETUP_SUB;
            tre_pkg::ST_SETUP_SUB: state_next = tre_pkg::ST_SETUP_CHK;
            tre_pkg::ST_SETUP_CHK:
                state_next = st.cull ? tre_pkg::ST_CULL : tre_pkg::ST_IDLE;
            tre_pkg::ST_CULL:
            begin
                if (!st.out_busy)
                    state_next = tre_pkg::ST_IDLE;
            end
            tre_pkg::ST_EDGE_MUL: state_next = tre_pkg::ST_EDGE_SUB;
            tre_pkg::ST_EDGE_SUB: state_next = tre_pkg::ST_EDGE_CHK;
            tre_pkg::ST_EDGE_CHK:
            begin
                cnt_next = '0;
                state_next = st.covered ? tre_pkg::ST_MAC : tre_pkg::ST_RESULT;
            end
            tre_pkg::ST_MAC:
            begin
                if (cnt_reg == tre_pkg::MAC_LAST)
                begin
                    cnt_next   = '0;
                    state_next = tre_pkg::ST_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            tre_pkg::ST_DIV:
            begin
                if (cnt_reg == tre_pkg::DIV_LAST)
                    state_next = tre_pkg::ST_DEPTH;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            tre_pkg::ST_DEPTH: state_next = tre_pkg::ST_RESULT;
            tre_pkg::ST_RESULT:
            begin
                if (!st.out_busy)
                    state_next = tre_pkg::ST_IDLE;
            end
            default: state_next = tre_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_ready = 1'b0;
        ctl       = '0;
        ctl.mac_sel = cnt_reg[1:0];
        unique case (state_reg)
            tre_pkg::ST_IDLE:
            begin
                cmd_ready    = 1'b1;
                ctl.load_vtx = cmd_valid && (cmd_op == tre_pkg::OP_LOAD);
            end
            tre_pkg::ST_SETUP_MUL: ctl.setup_mul = 1'b1;
            tre_pkg::ST_SETUP_SUB: ctl.setup_sub = 1'b1;
            tre_pkg::ST_SETUP_CHK: ctl.setup_commit = !st.cull;
            tre_pkg::ST_CULL:      ctl.cull_load = !st.out_busy;
            tre_pkg::ST_EDGE_MUL:  ctl.edge_mul = 1'b1;
            tre_pkg::ST_EDGE_SUB:  ctl.edge_sub = 1'b1;
            tre_pkg::ST_EDGE_CHK:  ;
            tre_pkg::ST_MAC:       ctl.mac_en = 1'b1;
            tre_pkg::ST_DIV:       ctl.div_step = 1'b1;
            tre_pkg::ST_DEPTH:     ctl.depth_mul = 1'b1;
            tre_pkg::ST_RESULT:    ctl.pixel_load = !st.out_busy;
            default: ;
        endcase
    end

endmodule

FILE: rtl/tre_datapath.sv
// Vertex store, edge evaluator, interpolation divider and result register.
module tre_datapath #(
    parameter int COORD_FRAC_BITS = 4,
    parameter int MAX_SCREEN      = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tre_pkg::cmd_payload_t  cmd_data,
    input  tre_pkg::dp_cmd_t       ctl,
    output tre_pkg::dp_status_t    st,
    tre_stream_if.sink             cfg,
    tre_stream_if.source           frag
);

    localparam int SX_W  = $clog2(MAX_SCREEN + 1);
    localparam int DP_W  = tre_pkg::POS_W + 1;
    localparam int PC_W  = SX_W + 2 + COORD_FRAC_BITS;
    localparam int PT_W  = (PC_W > DP_W) ? PC_W : DP_W;
    localparam int DF_W  = PT_W + 1;
    localparam int PR_W  = 2 * DF_W;
    localparam int W_W   = PR_W + 1;
    localparam int A_W   = W_W - 1;
    localparam int NUM_W = A_W + tre_pkg::QUO_W + 2;
    localparam int DS_W  = A_W + tre_pkg::QUO_W - 1;
    localparam int CL_A  = (SX_W + 2 > tre_pkg::POS_W + 1) ? SX_W + 2 : tre_pkg::POS_W + 1;
    localparam int CL_W  = (CL_A > tre_pkg::SCREEN_W + 1) ? CL_A : tre_pkg::SCREEN_W + 1;
    localparam int DP2_W = 2 * tre_pkg::DEPTH_W;

    // Configuration registers.
    logic [tre_pkg::SCREEN_W-1:0] screen_w_reg, screen_h_reg;
    logic [tre_pkg::DEPTH_W-1:0]  depth_scale_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_w_reg    <= tre_pkg::SCREEN_WIDTH_RST;
            screen_h_reg    <= tre_pkg::SCREEN_HEIGHT_RST;
            depth_scale_reg <= tre_pkg::DEPTH_SCALE_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                tre_pkg::CFG_SCREEN_WIDTH:
                    screen_w_reg <= cfg.data.wdata[tre_pkg::SCREEN_W-1:0];
                tre_pkg::CFG_SCREEN_HEIGHT:
                    screen_h_reg <= cfg.data.wdata[tre_pkg::SCREEN_W-1:0];
                tre_pkg::CFG_DEPTH_SCALE:
                    depth_scale_reg <= cfg.data.wdata;
                default: ;
            endcase
        end
    end

    // Vertex store.
    logic signed [tre_pkg::POS_W-1:0] vx_reg [tre_pkg::VTX_COUNT];
    logic signed [tre_pkg::POS_W-1:0] vy_reg [tre_pkg::VTX_COUNT];
    logic [tre_pkg::DEPTH_W-1:0]      vz_reg [tre_pkg::VTX_COUNT];
    logic [tre_pkg::COLOR_W-1:0]      vr_reg [tre_pkg::VTX_COUNT];
    logic [tre_pkg::COLOR_W-1:0]      vg_reg [tre_pkg::VTX_COUNT];
    logic [tre_pkg::COLOR_W-1:0]      vb_reg [tre_pkg::VTX_COUNT];

    always_ff @(posedge clk)
    begin
        if (ctl.load_vtx && (cmd_data.vertex_index <= tre_pkg::VTX_LAST))
        begin
            vx_reg[cmd_data.vertex_index] <= cmd_data.pos_x;
            vy_reg[cmd_data.vertex_index] <= cmd_data.pos_y;
            vz_reg[cmd_data.vertex_index] <= cmd_data.depth_in;
            vr_reg[cmd_data.vertex_index] <= cmd_data.red_in;
            vg_reg[cmd_data.vertex_index] <= cmd_data.green_in;
            vb_reg[cmd_data.vertex_index] <= cmd_data.blue_in;
        end
    end

    // Scan state.
    logic             scan_active_reg;
    logic [SX_W-1:0]  sx_reg, sy_reg;
    logic [SX_W-1:0]  bx0_reg, bx1_reg, by0_reg, by1_reg;
    logic             box_fail_reg;

    // Edge evaluation: doubled vertex positions and the sample point.
    logic signed [PT_W-1:0] ax [tre_pkg::VTX_COUNT];
    logic signed [PT_W-1:0] ay [tre_pkg::VTX_COUNT];
    logic signed [PT_W-1:0] px, py;

    always_comb
    begin
        for (int i = 0; i < tre_pkg::VTX_COUNT; i++)
        begin
            ax[i] = PT_W'($signed({vx_reg[i], 1'b0}));
            ay[i] = PT_W'($signed({vy_reg[i], 1'b0}));
        end
        if (ctl.setup_mul)
        begin
            px = ax[2];
            py = ay[2];
        end
        else
        begin
            px = $signed(PT_W'({sx_reg, 1'b1}) << COORD_FRAC_BITS);
            py = $signed(PT_W'({sy_reg, 1'b1}) << COORD_FRAC_BITS);
        end
    end

    logic signed [PR_W-1:0] pa_reg [tre_pkg::VTX_COUNT];
    logic signed [PR_W-1:0] pb_reg [tre_pkg::VTX_COUNT];
    logic signed [W_W-1:0]  w_next [tre_pkg::VTX_COUNT];
    logic signed [W_W-1:0]  w_reg  [tre_pkg::VTX_COUNT];
    logic [A_W-1:0]         m      [tre_pkg::VTX_COUNT];

    for (genvar e = 0; e < tre_pkg::VTX_COUNT; e++)
    begin : g_edge
        localparam int IA = (e + 1) % tre_pkg::VTX_COUNT;
        localparam int IB = (e + 2) % tre_pkg::VTX_COUNT;
        logic signed [DF_W-1:0] d_px, d_by, d_py, d_bx;
        logic signed [PR_W-1:0] prod_a, prod_b;

        assign d_px   = DF_W'(px) - DF_W'(ax[IA]);
        assign d_by   = DF_W'(ay[IB]) - DF_W'(ay[IA]);
        assign d_py   = DF_W'(py) - DF_W'(ay[IA]);
        assign d_bx   = DF_W'(ax[IB]) - DF_W'(ax[IA]);
        assign prod_a = d_px * d_by;
        assign prod_b = d_py * d_bx;

        always_ff @(posedge clk)
        begin
            if (ctl.setup_mul || ctl.edge_mul)
            begin
                pa_reg[e] <= prod_a;
                pb_reg[e] <= prod_b;
            end
        end

        assign w_next[e] = W_W'(pa_reg[e]) - W_W'(pb_reg[e]);
        assign m[e] = A_W'((w_reg[e] < 0) ? -w_reg[e] : w_reg[e]);
    end

    // Setup: signed area and the clamped bounding box.
    function automatic logic signed [CL_W-1:0] trunc_pix(
        input logic signed [tre_pkg::POS_W-1:0] v
    );
        logic signed [CL_W-1:0] ve;
        ve = CL_W'(v);
        trunc_pix = (ve < 0) ? -((-ve) >>> COORD_FRAC_BITS) : (ve >>> COORD_FRAC_BITS);
    endfunction

    logic signed [tre_pkg::POS_W-1:0] min_x, max_x, min_y, max_y;
    logic signed [CL_W-1:0] lo_x, hi_x, lo_y, hi_y, lim_x, lim_y, max_scr;
    logic signed [CL_W-1:0] bx0_n, bx1_n, by0_n, by1_n;
    logic                   fail_n;

    always_comb
    begin
        min_x = (vx_reg[0] < vx_reg[1]) ? vx_reg[0] : vx_reg[1];
        min_x = (min_x < vx_reg[2]) ? min_x : vx_reg[2];
        max_x = (vx_reg[0] > vx_reg[1]) ? vx_reg[0] : vx_reg[1];
        max_x = (max_x > vx_reg[2]) ? max_x : vx_reg[2];
        min_y = (vy_reg[0] < vy_reg[1]) ? vy_reg[0] : vy_reg[1];
        min_y = (min_y < vy_reg[2]) ? min_y : vy_reg[2];
        max_y = (vy_reg[0] > vy_reg[1]) ? vy_reg[0] : vy_reg[1];
        max_y = (max_y > vy_reg[2]) ? max_y : vy_reg[2];
        lo_x = trunc_pix(min_x);
        hi_x = trunc_pix(max_x);
        lo_y = trunc_pix(min_y);
        hi_y = trunc_pix(max_y);
        max_scr = $signed(CL_W'(MAX_SCREEN));
        lim_x = $signed(CL_W'(screen_w_reg));
        lim_y = $signed(CL_W'(screen_h_reg));
        if (lim_x > max_scr)
            lim_x = max_scr;
        if (lim_y > max_scr)
            lim_y = max_scr;
        bx0_n = (lo_x < 0) ? '0 : lo_x;
        bx1_n = (hi_x > lim_x) ? lim_x : hi_x;
        by0_n = (lo_y < 0) ? '0 : lo_y;
        by1_n = (hi_y > lim_y) ? lim_y : hi_y;
        fail_n = (lo_x > lim_x) || (hi_x < 0) || (lo_y > lim_y) || (hi_y < 0)
                 || (bx0_n >= bx1_n) || (by0_n >= by1_n);
    end

    logic signed [W_W-1:0] area_reg;
    logic [A_W-1:0]        aabs_reg;
    logic                  back_reg;
    logic                  covered_reg;
    logic                  covered_n;

    always_comb
    begin
        if (back_reg)
            covered_n = (w_next[0] <= 0) && (w_next[1] <= 0) && (w_next[2] <= 0);
        else
            covered_n = (w_next[0] >= 0) && (w_next[1] >= 0) && (w_next[2] >= 0);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.setup_sub)
        begin
            area_reg     <= w_next[2];
            bx0_reg      <= SX_W'(bx0_n);
            bx1_reg      <= SX_W'(bx1_n);
            by0_reg      <= SX_W'(by0_n);
            by1_reg      <= SX_W'(by1_n);
            box_fail_reg <= fail_n;
        end
        if (ctl.setup_commit)
        begin
            aabs_reg <= A_W'((area_reg < 0) ? -area_reg : area_reg);
            back_reg <= (area_reg < 0);
        end
        if (ctl.edge_sub)
        begin
            for (int i = 0; i < tre_pkg::VTX_COUNT; i++)
                w_reg[i] <= w_next[i];
            covered_reg <= covered_n;
        end
    end

    // Weighted sums, then a shared restoring divide by the area, one
    // quotient bit per cycle on all four attribute lanes.
    logic [tre_pkg::DEPTH_W-1:0] attr [tre_pkg::LANES];
    logic [NUM_W-1:0]            rem_reg [tre_pkg::LANES];
    logic [tre_pkg::QUO_W-1:0]   q_reg   [tre_pkg::LANES];
    logic [DS_W-1:0]             dsh_reg;
    logic [A_W-1:0]              m_sel;

    always_comb
    begin
        m_sel   = m[ctl.mac_sel];
        attr[0] = vz_reg[ctl.mac_sel];
        attr[1] = tre_pkg::DEPTH_W'(vr_reg[ctl.mac_sel]);
        attr[2] = tre_pkg::DEPTH_W'(vg_reg[ctl.mac_sel]);
        attr[3] = tre_pkg::DEPTH_W'(vb_reg[ctl.mac_sel]);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mac_en)
        begin
            if (ctl.mac_sel == '0)
                dsh_reg <= DS_W'(aabs_reg) << (tre_pkg::QUO_W - 1);
            for (int l = 0; l < tre_pkg::LANES; l++)
            begin
                rem_reg[l] <= ((ctl.mac_sel == '0) ? '0 : rem_reg[l])
                              + NUM_W'(m_sel) * NUM_W'(attr[l]);
                q_reg[l]   <= '0;
            end
        end
        else if (ctl.div_step)
        begin
            dsh_reg <= dsh_reg >> 1;
            for (int l = 0; l < tre_pkg::LANES; l++)
            begin
                if (rem_reg[l] >= NUM_W'(dsh_reg))
                begin
                    rem_reg[l] <= rem_reg[l] - NUM_W'(dsh_reg);
                    q_reg[l]   <= {q_reg[l][tre_pkg::QUO_W-2:0], 1'b1};
                end
                else
                begin
                    q_reg[l] <= {q_reg[l][tre_pkg::QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    // Depth scaling: product divided by 65535 with one correction step.
    logic [DP2_W-1:0]             dprod_reg;
    logic [tre_pkg::DEPTH_W-1:0]  dq0;
    logic [tre_pkg::DEPTH_W:0]    drem;
    logic [tre_pkg::DEPTH_W:0]    dfix;
    logic [tre_pkg::DEPTH_W-1:0]  depth_n;

    always_ff @(posedge clk)
    begin
        if (ctl.depth_mul)
            dprod_reg <= DP2_W'(q_reg[0]) * DP2_W'(depth_scale_reg);
    end

    always_comb
    begin
        dq0  = dprod_reg[DP2_W-1:tre_pkg::DEPTH_W];
        drem = (tre_pkg::DEPTH_W+1)'(dprod_reg[tre_pkg::DEPTH_W-1:0])
               + (tre_pkg::DEPTH_W+1)'(dq0);
        dfix = (tre_pkg::DEPTH_W+1)'(dq0)
               + ((drem >= (tre_pkg::DEPTH_W+1)'(tre_pkg::DEPTH_ONE)) ? 1'b1 : 1'b0);
        depth_n = (dfix > (tre_pkg::DEPTH_W+1)'(tre_pkg::DEPTH_ONE))
                  ? tre_pkg::DEPTH_ONE : dfix[tre_pkg::DEPTH_W-1:0];
    end

    function automatic logic [tre_pkg::COLOR_W-1:0] sat_color(
        input logic [tre_pkg::QUO_W-1:0] q
    );
        sat_color = (q > tre_pkg::QUO_W'(tre_pkg::COLOR_ONE))
                    ? tre_pkg::COLOR_ONE : q[tre_pkg::COLOR_W-1:0];
    endfunction

    // Scan stepping and the result register.
    logic [SX_W:0] sx_inc, sy_inc;
    logic          row_wrap, last_pix;

    assign sx_inc   = {1'b0, sx_reg} + 1'b1;
    assign sy_inc   = {1'b0, sy_reg} + 1'b1;
    assign row_wrap = (sy_inc >= {1'b0, by1_reg});
    assign last_pix = row_wrap && (sx_inc >= {1'b0, bx1_reg});

    logic                  out_valid_reg;
    tre_pkg::frag_payload_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.load_vtx && (cmd_data.vertex_index == tre_pkg::VTX_LAST))
                scan_active_reg <= 1'b0;
            else if (ctl.setup_commit)
                scan_active_reg <= 1'b1;
            else if (ctl.pixel_load && last_pix)
                scan_active_reg <= 1'b0;

            if (ctl.pixel_load || ctl.cull_load)
                out_valid_reg <= 1'b1;
            else if (frag.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.setup_commit)
        begin
            sx_reg <= bx0_reg;
            sy_reg <= by0_reg;
        end
        else if (ctl.pixel_load)
        begin
            if (row_wrap)
            begin
                sy_reg <= by0_reg;
                sx_reg <= sx_inc[SX_W-1:0];
            end
            else
            begin
                sy_reg <= sy_inc[SX_W-1:0];
            end
        end

        if (ctl.cull_load)
        begin
            out_reg           <= '0;
            out_reg.scan_done <= 1'b1;
        end
        else if (ctl.pixel_load)
        begin
            out_reg.fragment_valid <= covered_reg;
            out_reg.frag_x         <= tre_pkg::PIX_W'(sx_reg);
            out_reg.frag_y         <= tre_pkg::PIX_W'(sy_reg);
            out_reg.frag_depth     <= covered_reg ? depth_n : '0;
            out_reg.frag_red       <= covered_reg ? sat_color(q_reg[1]) : '0;
            out_reg.frag_green     <= covered_reg ? sat_color(q_reg[2]) : '0;
            out_reg.frag_blue      <= covered_reg ? sat_color(q_reg[3]) : '0;
            out_reg.scan_done      <= last_pix;
        end
    end

    assign frag.valid = out_valid_reg;
    assign frag.data  = out_reg;

    assign st.scan_active = scan_active_reg;
    assign st.cull        = (area_reg == 0) || box_fail_reg;
    assign st.covered     = covered_reg;
    assign st.out_busy    = out_valid_reg && !frag.ready;

endmodule

FILE: bench/tb_triangle_edge_rasterizer_core.sv
// Self-checking testbench for the triangle edge rasterizer core.
`timescale 1ns / 100ps

module tb_triangle_edge_rasterizer_core;

    localparam int  FRAC        = 4;
    localparam int  MAXSCR      = 4096;
    localparam int  SETTLE      = 40;
    localparam longint LIMIT    = 1000000;

    typedef longint coord3_t [3];

    logic clk;
    logic rst_n;

    tre_stream_if #(.payload_t(tre_pkg::cmd_payload_t))  cmd_ch ();
    tre_stream_if #(.payload_t(tre_pkg::frag_payload_t)) frag_ch ();
    tre_stream_if #(.payload_t(tre_pkg::cfg_payload_t))  cfg_ch ();

    triangle_edge_rasterizer_core #(
        .COORD_FRAC_BITS(FRAC),
        .MAX_SCREEN     (MAXSCR)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_ch.sink),
        .frag (frag_ch.source),
        .cfg  (cfg_ch.sink)
    );

    // Commands waiting to be driven, and fragments the shadow model has
    // already computed but the block has not yet delivered.
    tre_pkg::cmd_payload_t  cmd_backlog [$];
    tre_pkg::frag_payload_t frag_expected [$];

    int     send_idle_pct;
    int     recv_idle_pct;
    int     error_count;
    longint cycle_count;

    // Shadow copy of the configuration and of the scan state.
    int unsigned cur_width;
    int unsigned cur_height;
    int unsigned cur_dscale;
    coord3_t     shadow_x;
    coord3_t     shadow_y;
    int unsigned shadow_z [3];
    int unsigned shadow_r [3];
    int unsigned shadow_g [3];
    int unsigned shadow_b [3];
    longint unsigned area_abs;
    bit     rear_facing;
    bit     scanning;
    longint box_x0, box_x1, box_y0, box_y1;
    longint scan_x, scan_y;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint edge_fn(input longint ax, input longint ay,
                                       input longint bx, input longint by,
                                       input longint cx, input longint cy);
        return (cx - ax) * (by - ay) - (cy - ay) * (bx - ax);
    endfunction

    function automatic longint to_pixel(input longint v);
        if (v >= 0)
            return v >>> FRAC;
        return -((-v) >>> FRAC);
    endfunction

    // Triangle setup: returns 1 when the triangle is culled. The same routine
    // also sizes the step run in the stimulus generator.
    function automatic bit tri_setup(input coord3_t px, input coord3_t py,
                                     input int unsigned sw, input int unsigned sh,
                                     output longint area, output longint x0,
                                     output longint x1, output longint y0,
                                     output longint y1);
        longint w, h, lo, hi;
        x0 = 0; x1 = 0; y0 = 0; y1 = 0;
        area = edge_fn(2 * px[0], 2 * py[0], 2 * px[1], 2 * py[1], 2 * px[2], 2 * py[2]);
        if (area == 0)
            return 1'b1;
        w = (sw < MAXSCR) ? sw : MAXSCR;
        h = (sh < MAXSCR) ? sh : MAXSCR;
        lo = to_pixel((px[0] < px[1]) ? ((px[0] < px[2]) ? px[0] : px[2])
                                      : ((px[1] < px[2]) ? px[1] : px[2]));
        hi = to_pixel((px[0] > px[1]) ? ((px[0] > px[2]) ? px[0] : px[2])
                                      : ((px[1] > px[2]) ? px[1] : px[2]));
        if (lo > w || hi < 0)
            return 1'b1;
        x0 = (lo < 0) ? 0 : lo;
        x1 = (hi > w) ? w : hi;
        lo = to_pixel((py[0] < py[1]) ? ((py[0] < py[2]) ? py[0] : py[2])
                                      : ((py[1] < py[2]) ? py[1] : py[2]));
        hi = to_pixel((py[0] > py[1]) ? ((py[0] > py[2]) ? py[0] : py[2])
                                      : ((py[1] > py[2]) ? py[1] : py[2]));
        if (lo > h || hi < 0)
            return 1'b1;
        y0 = (lo < 0) ? 0 : lo;
        y1 = (hi > h) ? h : hi;
        return (x0 >= x1 || y0 >= y1);
    endfunction

    function automatic longint unsigned blend(input longint unsigned m0,
                                              input longint unsigned m1,
                                              input longint unsigned m2,
                                              input int unsigned a0,
                                              input int unsigned a1,
                                              input int unsigned a2);
        return (m0 * a0 + m1 * a1 + m2 * a2) / area_abs;
    endfunction

    // Advances the shadow model by one accepted command transaction and
    // queues the fragment it produces, if any.
    task automatic predict_fragment(input tre_pkg::cmd_payload_t c);
        tre_pkg::frag_payload_t f;
        int              k;
        longint          area, cx, cy, w0, w1, w2;
        longint unsigned m0, m1, m2, d;
        bit              covered;
        f = '0;
        if (c.op == tre_pkg::OP_LOAD)
        begin
            k = c.vertex_index;
            if (k > tre_pkg::VTX_LAST)
                return;
            shadow_x[k] = longint'(c.pos_x);
            shadow_y[k] = longint'(c.pos_y);
            shadow_z[k] = c.depth_in;
            shadow_r[k] = c.red_in;
            shadow_g[k] = c.green_in;
            shadow_b[k] = c.blue_in;
            if (k != tre_pkg::VTX_LAST)
                return;
            scanning = 1'b0;
            if (tri_setup(shadow_x, shadow_y, cur_width, cur_height, area,
                          box_x0, box_x1, box_y0, box_y1))
            begin
                f.scan_done = 1'b1;
                frag_expected.push_back(f);
                return;
            end
            rear_facing = (area < 0);
            area_abs    = (area < 0) ? -area : area;
            scan_x      = box_x0;
            scan_y      = box_y0;
            scanning    = 1'b1;
            return;
        end
        if (!scanning)
            return;
        // Pixel centre in doubled coordinates, so the half pixel is exact.
        cx = (2 * scan_x + 1) * (64'sd1 << FRAC);
        cy = (2 * scan_y + 1) * (64'sd1 << FRAC);
        w0 = edge_fn(2 * shadow_x[1], 2 * shadow_y[1], 2 * shadow_x[2], 2 * shadow_y[2], cx, cy);
        w1 = edge_fn(2 * shadow_x[2], 2 * shadow_y[2], 2 * shadow_x[0], 2 * shadow_y[0], cx, cy);
        w2 = edge_fn(2 * shadow_x[0], 2 * shadow_y[0], 2 * shadow_x[1], 2 * shadow_y[1], cx, cy);
        if (rear_facing)
            covered = (w0 <= 0) && (w1 <= 0) && (w2 <= 0);
        else
            covered = (w0 >= 0) && (w1 >= 0) && (w2 >= 0);
        f.frag_x = scan_x[tre_pkg::PIX_W-1:0];
        f.frag_y = scan_y[tre_pkg::PIX_W-1:0];
        if (covered)
        begin
            m0 = (w0 < 0) ? -w0 : w0;
            m1 = (w1 < 0) ? -w1 : w1;
            m2 = (w2 < 0) ? -w2 : w2;
            f.fragment_valid = 1'b1;
            d = blend(m0, m1, m2, shadow_z[0], shadow_z[1], shadow_z[2]);
            if (d > 65535)
                d = 65535;
            d = d * cur_dscale / 65535;
            f.frag_depth = (d > 65535) ? 16'hFFFF : d[15:0];
            d = blend(m0, m1, m2, shadow_r[0], shadow_r[1], shadow_r[2]);
            f.frag_red = (d > 255) ? 8'hFF : d[7:0];
            d = blend(m0, m1, m2, shadow_g[0], shadow_g[1], shadow_g[2]);
            f.frag_green = (d > 255) ? 8'hFF : d[7:0];
            d = blend(m0, m1, m2, shadow_b[0], shadow_b[1], shadow_b[2]);
            f.frag_blue = (d > 255) ? 8'hFF : d[7:0];
        end
        scan_y++;
        if (scan_y >= box_y1)
        begin
            scan_y = box_y0;
            scan_x++;
            if (scan_x >= box_x1)
            begin
                scanning    = 1'b0;
                f.scan_done = 1'b1;
            end
        end
        frag_expected.push_back(f);
    endtask

    // Driver: the shadow model sees each command at the edge it is accepted,
    // then the next one is offered unless the sender is idling this cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.data  <= '0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                predict_fragment(cmd_ch.data);
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cmd_ch.data  <= cmd_backlog.pop_front();
                    cmd_ch.valid <= 1'b1;
                end
                else
                begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Monitor: every fragment transaction is matched against the oldest
    // prediction; ready toggles at random to stall the block.
    always @(posedge clk or negedge rst_n)
    begin
        tre_pkg::frag_payload_t want;
        if (!rst_n)
        begin
            frag_ch.ready <= 1'b0;
        end
        else
        begin
            if (frag_ch.valid && frag_ch.ready)
            begin
                if (frag_expected.size() == 0)
                begin
                    $display("%0t: unexpected fragment, expected none, actual %p",
                             $time, frag_ch.data);
                    error_count++;
                end
                else
                begin
                    want = frag_expected.pop_front();
                    check_field("fragment_valid", want.fragment_valid, frag_ch.data.fragment_valid);
                    check_field("frag_x", want.frag_x, frag_ch.data.frag_x);
                    check_field("frag_y", want.frag_y, frag_ch.data.frag_y);
                    check_field("frag_depth", want.frag_depth, frag_ch.data.frag_depth);
                    check_field("frag_red", want.frag_red, frag_ch.data.frag_red);
                    check_field("frag_green", want.frag_green, frag_ch.data.frag_green);
                    check_field("frag_blue", want.frag_blue, frag_ch.data.frag_blue);
                    check_field("scan_done", want.scan_done, frag_ch.data.scan_done);
                end
            end
            frag_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("tb_triangle_edge_rasterizer_core: done, errors");
            $finish;
        end
    end

    function automatic tre_pkg::cmd_payload_t make_cmd(input logic op, input logic [1:0] idx,
                                              input longint x, input longint y,
                                              input int unsigned z, input int unsigned r,
                                              input int unsigned g, input int unsigned b);
        tre_pkg::cmd_payload_t c;
        c.op           = op;
        c.vertex_index = idx;
        c.pos_x        = x[tre_pkg::POS_W-1:0];
        c.pos_y        = y[tre_pkg::POS_W-1:0];
        c.depth_in     = z[tre_pkg::DEPTH_W-1:0];
        c.red_in       = r[tre_pkg::COLOR_W-1:0];
        c.green_in     = g[tre_pkg::COLOR_W-1:0];
        c.blue_in      = b[tre_pkg::COLOR_W-1:0];
        return c;
    endfunction

    function automatic tre_pkg::cmd_payload_t step_cmd();
        return make_cmd(tre_pkg::OP_STEP, 2'($urandom), longint'($urandom),
                        longint'($urandom), $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Loads three vertices and queues steps to cover the box, as sized by
    // the same setup routine the shadow model uses; a cut below that caps the steps.
    task automatic queue_triangle(input coord3_t px, input coord3_t py, input int cut);
        longint area, x0, x1, y0, y1, n;
        int     i;
        for (i = 0; i < 3; i++)
        begin
            cmd_backlog.push_back(make_cmd(tre_pkg::OP_LOAD, 2'(i), px[i], py[i],
                ($urandom_range(7) == 0) ? 65535 : $urandom_range(65535),
                ($urandom_range(5) == 0) ? 255 : $urandom_range(255),
                ($urandom_range(5) == 0) ? 0 : $urandom_range(255),
                $urandom_range(255)));
        end
        if (tri_setup(px, py, cur_width, cur_height, area, x0, x1, y0, y1))
            n = 0;
        else
            n = (x1 - x0) * (y1 - y0);
        if (cut >= 0 && cut < n)
            n = cut;
        repeat (n) cmd_backlog.push_back(step_cmd());
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (cmd_backlog.size() != 0 || cmd_ch.valid || frag_expected.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [tre_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned value);
        @(posedge clk);
        cfg_ch.data.index <= idx;
        cfg_ch.data.wdata <= value[tre_pkg::CFG_DATA_W-1:0];
        cfg_ch.valid      <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == tre_pkg::CFG_SCREEN_WIDTH)
            cur_width = value & 16'h1FFF;
        else if (idx == tre_pkg::CFG_SCREEN_HEIGHT)
            cur_height = value & 16'h1FFF;
        else if (idx == tre_pkg::CFG_DEPTH_SCALE)
            cur_dscale = value & 16'hFFFF;
    endtask

    initial
    begin
        coord3_t     px, py;
        int unsigned widths [6];
        int unsigned heights [6];
        int unsigned scales [6];
        int          phase, budget, i, base_x, base_y;
        longint      lo, hi;

        clk           = 1'b0;
        rst_n         = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        send_idle_pct = 19;
        recv_idle_pct = 60;
        cur_width     = tre_pkg::SCREEN_WIDTH_RST;
        cur_height    = tre_pkg::SCREEN_HEIGHT_RST;
        cur_dscale    = tre_pkg::DEPTH_SCALE_RST;
        scanning      = 1'b0;
        area_abs      = 0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;

        widths  = '{640, 16, 4096, 1, 8191, 20 + $urandom_range(180)};
        heights = '{480, 12, 4096, 1, 8191, 20 + $urandom_range(180)};
        scales  = '{65535, 1, 32768, $urandom_range(1, 65535), 65535,
                    $urandom_range(1, 65535)};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, at reset configuration.
        lo = -524288;
        hi = 524287;
        // A step before any triangle exists is absorbed.
        cmd_backlog.push_back(step_cmd());
        // Back face with the colour and depth extremes.
        cmd_backlog.push_back(make_cmd(tre_pkg::OP_LOAD, 2'd0, 16, 8, 0, 0, 255, 0));
        cmd_backlog.push_back(make_cmd(tre_pkg::OP_LOAD, 2'd1, 70, 20, 65535, 255, 0, 255));
        cmd_backlog.push_back(make_cmd(tre_pkg::OP_LOAD, 2'd2, 30, 60, 65535, 255, 255, 0));
        repeat (12) cmd_backlog.push_back(step_cmd());
        // The same triangle wound the other way is a front face.
        px = '{16, 30, 70}; py = '{8, 60, 20};
        queue_triangle(px, py, -1);
        // Collinear vertices have zero area and are culled.
        px = '{0, 32, 64}; py = '{0, 32, 64};
        queue_triangle(px, py, -1);
        // Entirely left of and above the screen.
        px = '{-100, -40, -80}; py = '{-90, -30, -10};
        queue_triangle(px, py, -1);
        // Inside a single pixel, so the box is empty.
        px = '{33, 40, 35}; py = '{34, 36, 44};
        queue_triangle(px, py, -1);
        // Vertex index three is ignored.
        cmd_backlog.push_back(make_cmd(tre_pkg::OP_LOAD, 2'd3, hi, lo, 65535, 255, 255, 255));
        // Position extremes give a box clamped to the screen; the scan is
        // disturbed by a vertex 1 overwrite and then restarted by vertex 2.
        px = '{lo, hi, lo}; py = '{lo, lo, hi};
        queue_triangle(px, py, 3);
        cmd_backlog.push_back(make_cmd(tre_pkg::OP_LOAD, 2'd1, hi, hi, 12345, 17, 99, 200));
        repeat (2) cmd_backlog.push_back(step_cmd());
        px = '{hi, lo, hi}; py = '{hi, hi, lo};
        queue_triangle(px, py, 2);
        wait_idle();

        for (phase = 0; phase < 6; phase++)
        begin
            if (phase < 2)
            begin
                send_idle_pct = 19;
                recv_idle_pct = 60;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 60;
                recv_idle_pct = 19;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            cfg_write(tre_pkg::CFG_SCREEN_WIDTH, widths[phase]);
            cfg_write(tre_pkg::CFG_SCREEN_HEIGHT, heights[phase]);
            cfg_write(tre_pkg::CFG_DEPTH_SCALE, scales[phase]);

            budget = 0;
            while (budget < 310)
            begin
                i = cmd_backlog.size();
                if ($urandom_range(9) < 8)
                begin
                    // Small triangle, sometimes hugging the right or bottom
                    // edge of the screen so the clamp is exercised.
                    base_x = ($urandom_range(3) == 0) ? int'(cur_width) - $urandom_range(6)
                                                      : $urandom_range(20) - 3;
                    base_y = ($urandom_range(3) == 0) ? int'(cur_height) - $urandom_range(6)
                                                      : $urandom_range(20) - 3;
                    for (int v = 0; v < 3; v++)
                    begin
                        px[v] = longint'(base_x) * 16 + longint'($urandom_range(96));
                        py[v] = longint'(base_y) * 16 + longint'($urandom_range(96));
                    end
                    if ($urandom_range(15) == 0)
                    begin
                        px[2] = 2 * px[1] - px[0];
                        py[2] = 2 * py[1] - py[0];
                    end
                    queue_triangle(px, py, ($urandom_range(7) == 0) ? $urandom_range(5) : -1);
                    repeat ($urandom_range(2) == 0) cmd_backlog.push_back(step_cmd());
                end
                else
                begin
                    // Noise: any op, any index, any position.
                    cmd_backlog.push_back(make_cmd(1'($urandom), 2'($urandom),
                                                   longint'($urandom), longint'($urandom),
                                                   $urandom, $urandom, $urandom, $urandom));
                end
                budget += cmd_backlog.size() - i;
                while (cmd_backlog.size() > 64)
                    @(posedge clk);
            end
            wait_idle();
        end

        if (error_count == 0)
            $display("tb_triangle_edge_rasterizer_core: done, clean");
        else
            $display("tb_triangle_edge_rasterizer_core: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/tre_pkg.sv
rtl/tre_stream_if.sv
rtl/tre_ctrl.sv
rtl/tre_datapath.sv
rtl/triangle_edge_rasterizer_core.sv
bench/tb_triangle_edge_rasterizer_core.sv
